// ===== rtl/core/blq_pkg.sv =====
package blq_pkg;

  localparam int NUM_STACKS  = 8;
  localparam int STACK_DEPTH = 16;

  localparam int NUM_SLOTS = NUM_STACKS * STACK_DEPTH;
  localparam int SIDX_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [2:0] ST_PUSHED  = 3'd0;
  localparam logic [2:0] ST_POPPED  = 3'd1;
  localparam logic [2:0] ST_STOLEN  = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  typedef struct packed {
    logic        command;
    logic [15:0] request_num;
    logic [15:0] token_num;
    logic [7:0]  expert_num;
    logic [7:0]  priority_req;
    logic [7:0]  preferred_expert;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] task_request;
    logic [15:0] task_token;
    logic [7:0]  task_expert;
    logic [7:0]  task_priority;
    logic [2:0]  stack_served;
  } rsp_word_t;

  typedef struct packed {
    logic [15:0] req;
    logic [15:0] tok;
    logic [7:0]  exp;
    logic [7:0]  pri;
  } slot_t;

endpackage

// ===== rtl/core/blq_if.sv =====
interface blq_req_if;
  logic                 valid;
  logic                 ready;
  blq_pkg::req_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface blq_rsp_if;
  logic                 valid;
  logic                 ready;
  blq_pkg::rsp_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/banked_lifo_task_queue_with_stealing_core.sv =====
// Banked LIFO task queue with work stealing. Each accepted word (push or pop) gives exactly
// one response word, in the cycle after acceptance; a new word is accepted every cycle while
// the response register is empty or being drained. Pushes go to stack expert_num mod
// NUM_STACKS and are refused (status 4) when that stack is full. Pops serve the top of the
// preferred stack, else steal the top of the lowest-numbered other non-empty stack, else
// report nothing found (status 3). Task fields of the response are zero unless a task was
// popped. Fill counts live in flops and clear at reset; task storage is a single-port RAM
// whose registered read data forms the response payload, so no clearing pass is needed.
module banked_lifo_task_queue_with_stealing_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  blq_req_if.sink        in_i,
  blq_rsp_if.source      out_o
);

  localparam int SIDX_W = blq_pkg::SIDX_W;
  localparam int FILL_W = blq_pkg::FILL_W;
  localparam int ADDR_W = blq_pkg::ADDR_W;

  logic [FILL_W-1:0] fill_q [blq_pkg::NUM_STACKS];
  logic [FILL_W-1:0] fill_d [blq_pkg::NUM_STACKS];

  blq_pkg::slot_t mem [blq_pkg::NUM_SLOTS];
  blq_pkg::slot_t rdata_q;

  logic              valid_q;
  logic [2:0]        status_q;
  logic [2:0]        served_q;
  logic              hit_q;

  logic              accept;
  logic              is_push;
  logic [SIDX_W-1:0] push_idx;
  logic [SIDX_W-1:0] pref_idx;
  logic [SIDX_W-1:0] steal_idx;
  logic [SIDX_W-1:0] pop_idx;
  logic              steal_found;
  logic              own_hit;
  logic              pop_ok;
  logic              push_full;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [FILL_W-1:0] pop_fill;
  logic [2:0]        status_d;
  logic [SIDX_W-1:0] served_idx;
  blq_pkg::slot_t    wr_slot;

  assign in_i.ready = !valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_push    = (in_i.data.command == blq_pkg::CMD_PUSH);

  assign push_idx = SIDX_W'(in_i.data.expert_num % blq_pkg::NUM_STACKS);
  assign pref_idx = SIDX_W'(in_i.data.preferred_expert % blq_pkg::NUM_STACKS);

  assign own_hit   = (fill_q[pref_idx] != '0);
  assign push_full = (fill_q[push_idx] == FILL_W'(blq_pkg::STACK_DEPTH));

  // lowest-numbered non-empty stack other than the preferred one
  always_comb begin
    steal_found = 1'b0;
    steal_idx   = '0;
    for (int i = 0; i < blq_pkg::NUM_STACKS; i++) begin
      if (!steal_found && (SIDX_W'(i) != pref_idx) && (fill_q[i] != '0)) begin
        steal_found = 1'b1;
        steal_idx   = SIDX_W'(i);
      end
    end
  end

  assign pop_idx  = own_hit ? pref_idx : steal_idx;
  assign pop_ok   = own_hit || steal_found;
  assign pop_fill = fill_q[pop_idx] - FILL_W'(1);

  assign wr_addr = ADDR_W'(push_idx * blq_pkg::STACK_DEPTH) + ADDR_W'(fill_q[push_idx]);
  assign rd_addr = ADDR_W'(pop_idx * blq_pkg::STACK_DEPTH) + ADDR_W'(pop_fill);

  assign wr_slot.req = in_i.data.request_num;
  assign wr_slot.tok = in_i.data.token_num;
  assign wr_slot.exp = in_i.data.expert_num;
  assign wr_slot.pri = in_i.data.priority_req;

  always_comb begin
    if (is_push) begin
      status_d   = push_full ? blq_pkg::ST_REFUSED : blq_pkg::ST_PUSHED;
      served_idx = push_idx;
    end else if (own_hit) begin
      status_d   = blq_pkg::ST_POPPED;
      served_idx = pref_idx;
    end else if (steal_found) begin
      status_d   = blq_pkg::ST_STOLEN;
      served_idx = steal_idx;
    end else begin
      status_d   = blq_pkg::ST_NONE;
      served_idx = pref_idx;
    end
  end

  always_comb begin
    for (int i = 0; i < blq_pkg::NUM_STACKS; i++) begin
      fill_d[i] = fill_q[i];
    end
    if (accept) begin
      if (is_push) begin
        if (!push_full) begin
          fill_d[push_idx] = fill_q[push_idx] + FILL_W'(1);
        end
      end else if (pop_ok) begin
        fill_d[pop_idx] = pop_fill;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < blq_pkg::NUM_STACKS; i++) begin
        fill_q[i] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < blq_pkg::NUM_STACKS; i++) begin
        fill_q[i] <= fill_d[i];
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      served_q <= 3'(served_idx);
      hit_q    <= !is_push && pop_ok;
    end
  end

  // task RAM: at most one access per accepted word, read data registered
  always_ff @(posedge clk_i) begin
    if (accept && is_push && !push_full) begin
      mem[wr_addr] <= wr_slot;
    end
    if (accept && !is_push && pop_ok) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_o.valid              = valid_q;
  assign out_o.data.status        = status_q;
  assign out_o.data.stack_served  = served_q;
  assign out_o.data.task_request  = hit_q ? rdata_q.req : '0;
  assign out_o.data.task_token    = hit_q ? rdata_q.tok : '0;
  assign out_o.data.task_expert   = hit_q ? rdata_q.exp : '0;
  assign out_o.data.task_priority = hit_q ? rdata_q.pri : '0;

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("accepted word gave no response");

  a_push_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_push && push_full) |=> (status_q == blq_pkg::ST_REFUSED)
      && (fill_q[$past(push_idx)] == FILL_W'(blq_pkg::STACK_DEPTH)))
    else $error("push into full stack not refused");

  a_own_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_push && own_hit) |=> (status_q == blq_pkg::ST_POPPED)
      && (fill_q[$past(pref_idx)] == $past(fill_q[pref_idx]) - FILL_W'(1)))
    else $error("pop of non-empty preferred stack mishandled");

  a_hit_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (hit_q == ((status_q == blq_pkg::ST_POPPED)
      || (status_q == blq_pkg::ST_STOLEN))))
    else $error("task payload flag disagrees with status");

endmodule
